// File: hw/rtl/shfp_pkg.sv
// Package for the server hello field parser: parse phases, result kinds,
// the result record passed from the parser core to the top level.
// No dependencies.
package shfp_pkg;

  // Number of random bytes in the hello message (1 to 63)
  localparam int unsigned RandomBytes = 32;
  localparam int unsigned CountW      = 6;

  // Parse phases, one-hot
  typedef enum logic [12:0] {
    PH_LEN    = 13'd1,
    PH_FLAG   = 13'd2,
    PH_VER    = 13'd4,
    PH_CIPHER = 13'd8,
    PH_RANDOM = 13'd16,
    PH_EXTLEN = 13'd32,
    PH_EXTCNT = 13'd64,
    PH_PKGLEN = 13'd128,
    PH_TYPE   = 13'd256,
    PH_ARRIDX = 13'd512,
    PH_DLEN   = 13'd1024,
    PH_DATA   = 13'd2048,
    PH_DONE   = 13'd4096
  } phase_e;

  // Kind of a result transaction
  typedef enum logic [2:0] {
    KIND_VERSION   = 3'd0,
    KIND_CIPHER    = 3'd1,
    KIND_RANDOM    = 3'd2,
    KIND_EXT_START = 3'd3,
    KIND_EXT_DATA  = 3'd4,
    KIND_END       = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [15:0] ext_type;
    logic [15:0] index;
    logic        msg_end;
    logic        len_err;
  } res_t;

  // Byte length of each fixed-size field phase
  function automatic logic [CountW-1:0] phase_len(phase_e ph);
    logic [CountW-1:0] n;
    unique case (ph)
      PH_LEN, PH_EXTLEN, PH_PKGLEN, PH_ARRIDX: n = CountW'(4);
      PH_FLAG, PH_EXTCNT:                      n = CountW'(1);
      PH_VER, PH_CIPHER, PH_TYPE, PH_DLEN:     n = CountW'(2);
      default:                                 n = CountW'(0);
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/shfp_core.sv
// Parser core: holds the parse state and turns one byte per step into at
// most one result record. Depends on shfp_pkg.
module shfp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output logic           res_valid_o,
  output shfp_pkg::res_t res_o
);
  import shfp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [31:0]         acc_q, acc_d;
  logic [31:0]         dlen_q, dlen_d;
  logic [31:0]         seen_q, seen_d;
  logic [7:0]          ext_left_q, ext_left_d;
  logic [15:0]         data_left_q, data_left_d;
  logic [15:0]         ext_type_q, ext_type_d;

  logic                have;
  res_t                res;
  logic [CountW-1:0]   cnt_inc;
  logic [31:0]         acc_shift;

  // Work out next state and the result for the current byte
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    dlen_d      = dlen_q;
    ext_left_d  = ext_left_q;
    data_left_d = data_left_q;
    ext_type_d  = ext_type_q;
    have        = 1'b0;
    res         = '{kind: KIND_END, value: '0, ext_type: '0, index: '0,
                    msg_end: 1'b0, len_err: 1'b0};
    seen_d      = (seen_q == '1) ? seen_q : seen_q + 32'd1;
    cnt_inc     = cnt_q + CountW'(1);
    acc_shift   = {acc_q[23:0], byte_i};

    unique case (phase_q)
      PH_RANDOM: begin
        have      = 1'b1;
        res.kind  = KIND_RANDOM;
        res.value = {8'd0, byte_i};
        res.index = 16'(cnt_q);
        cnt_d     = cnt_inc;
        if (cnt_inc >= CountW'(RandomBytes)) begin
          cnt_d   = '0;
          phase_d = PH_EXTLEN;
        end
      end
      PH_DATA: begin
        have         = 1'b1;
        res.kind     = KIND_EXT_DATA;
        res.value    = {8'd0, byte_i};
        res.ext_type = ext_type_q;
        res.index    = acc_q[15:0] - data_left_q;
        data_left_d  = data_left_q - 16'd1;
        if (data_left_d == '0) begin
          ext_left_d = ext_left_q - 8'd1;
          phase_d    = (ext_left_d == '0) ? PH_DONE : PH_PKGLEN;
        end
      end
      PH_LEN, PH_FLAG, PH_VER, PH_CIPHER, PH_EXTLEN, PH_EXTCNT,
      PH_PKGLEN, PH_TYPE, PH_ARRIDX, PH_DLEN: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (cnt_inc >= phase_len(phase_q)) begin
          cnt_d = '0;
          acc_d = '0;
          unique case (phase_q)
            PH_LEN: begin
              dlen_d  = acc_shift;
              phase_d = PH_FLAG;
            end
            PH_FLAG:   phase_d = PH_VER;
            PH_VER: begin
              have      = 1'b1;
              res.kind  = KIND_VERSION;
              res.value = {acc_shift[7:0], acc_shift[15:8]};
              phase_d   = PH_CIPHER;
            end
            PH_CIPHER: begin
              have      = 1'b1;
              res.kind  = KIND_CIPHER;
              res.value = acc_shift[15:0];
              phase_d   = PH_RANDOM;
            end
            PH_EXTLEN: phase_d = PH_EXTCNT;
            PH_EXTCNT: begin
              ext_left_d = acc_shift[7:0];
              phase_d    = (acc_shift[7:0] == '0) ? PH_DONE : PH_PKGLEN;
            end
            PH_PKGLEN: phase_d = PH_TYPE;
            PH_TYPE: begin
              ext_type_d = acc_shift[15:0];
              phase_d    = PH_ARRIDX;
            end
            PH_ARRIDX: phase_d = PH_DLEN;
            PH_DLEN: begin
              have         = 1'b1;
              res.kind     = KIND_EXT_START;
              res.value    = acc_shift[15:0];
              res.ext_type = ext_type_q;
              data_left_d  = acc_shift[15:0];
              if (acc_shift[15:0] == '0) begin
                ext_left_d = ext_left_q - 8'd1;
                phase_d    = (ext_left_d == '0) ? PH_DONE : PH_PKGLEN;
              end else begin
                acc_d   = {16'd0, acc_shift[15:0]};
                phase_d = PH_DATA;
              end
            end
            default: ;
          endcase
        end
      end
      default: ; // done phase: drop the byte
    endcase

    // Close the message on the last byte and return to the reset state
    if (last_i) begin
      res.msg_end = 1'b1;
      res.len_err = ({1'b0, seen_d} != ({1'b0, dlen_d} + 33'd4)) ||
                    (phase_d != PH_DONE);
      phase_d     = PH_LEN;
      cnt_d       = '0;
      acc_d       = '0;
      dlen_d      = '0;
      seen_d      = '0;
      ext_left_d  = '0;
      data_left_d = '0;
      ext_type_d  = '0;
    end
  end

  assign res_valid_o = have || last_i;
  assign res_o       = res;

  // Advance the parse state once per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      cnt_q       <= '0;
      acc_q       <= '0;
      dlen_q      <= '0;
      seen_q      <= '0;
      ext_left_q  <= '0;
      data_left_q <= '0;
      ext_type_q  <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      dlen_q      <= dlen_d;
      seen_q      <= seen_d;
      ext_left_q  <= ext_left_d;
      data_left_q <= data_left_d;
      ext_type_q  <= ext_type_d;
    end
  end

  // A processed last byte leaves the parser ready for a new message
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PH_LEN && seen_q == '0)
    else $error("parser did not restart after last byte");

  // Data phase always has bytes outstanding
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> data_left_q != '0)
    else $error("data phase with no bytes left");

  // Extension phases always have an extension outstanding
  a_ext_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PKGLEN || phase_q == PH_TYPE || phase_q == PH_ARRIDX ||
     phase_q == PH_DLEN || phase_q == PH_DATA) |-> ext_left_q != '0)
    else $error("extension phase with zero extensions left");

  // An error is only reported on the closing transaction
  a_err_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.len_err |-> res_o.msg_end && last_i)
    else $error("length error outside message end");

endmodule

// File: hw/rtl/server_hello_field_parser.sv
// Path: an accepted byte waits in the input register, and its result, if it has
// one, goes to the result register. Throughput: one byte per clock unless stalled.
// A stalled output holds its result while the input register waits behind it.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the length field phase.
// Top level of the server hello parser; depends on shfp_pkg and shfp_core.
module server_hello_field_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  field_kind_o,
  output logic [15:0] field_value_o,
  output logic [15:0] extension_type_o,
  output logic [15:0] byte_index_o,
  output logic        message_end_o,
  output logic        length_error_o
);
  import shfp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       advance;
  logic       res_valid;
  res_t       res;

  // Move the held byte through the parser when the output register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  shfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign field_kind_o     = 3'(out_q.kind);
  assign field_value_o    = out_q.value;
  assign extension_type_o = out_q.ext_type;
  assign byte_index_o     = out_q.index;
  assign message_end_o    = out_q.msg_end;
  assign length_error_o   = out_q.len_err;

endmodule
